// ----- design/mfdf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdf_pkg: shared types and constants of the mesh flood duplicate filter
// Command codes, result status codes, register indexes and the records
// that move between the front end, the command queue and the scan engine.
// ----------------------------------------------------------------------------
package mfdf_pkg;

  localparam logic [31:0] BROADCAST_NODE = 32'hFFFF_FFFF;
  localparam logic [31:0] TTL_RESET      = 32'(10 * 60 * 1000);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MY_NODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL_MS  = 1'd1;

  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_DUPLICATE  = 2'd1;
  localparam logic [1:0] ST_COLLISION  = 2'd2;
  localparam logic [1:0] ST_REGISTERED = 2'd3;

  localparam logic [1:0] KIND_RX   = 2'd0;
  localparam logic [1:0] KIND_OWN  = 2'd1;
  localparam logic [1:0] KIND_COLL = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] src_node;
    logic [31:0] packet_id;
    logic [39:0] now_ms;
    logic        deliver;
    logic        send_ack;
    logic        relay;
    logic [2:0]  relay_hops;
  } cmd_t;

  typedef struct packed {
    logic [31:0] source;
    logic [31:0] ident;
    logic [39:0] stamp;
  } entry_t;

endpackage

// ----- design/mfdf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdf_front: request front end
// Holds the configuration registers, takes header transfers and classifies
// them into queue commands with the delivery, ack and relay flags resolved.
// ----------------------------------------------------------------------------
module mfdf_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [31:0]                    in_src_node,
  input  logic [31:0]                    in_dst_node,
  input  logic [31:0]                    in_packet_id,
  input  logic [2:0]                     in_hops_left,
  input  logic                           in_ack_wanted,
  input  logic [39:0]                    in_now_ms,
  input  logic                           cfg_we,
  input  logic [mfdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           q_full,
  input  logic                           clearing,
  output logic                           push,
  output mfdf_pkg::cmd_t                 push_item,
  output logic [31:0]                    ttl_ms
);

  logic [31:0] my_node_r, my_node_nxt;
  logic [31:0] ttl_ms_r, ttl_ms_nxt;
  logic        dst_me;

  always_comb begin
    my_node_nxt = my_node_r;
    ttl_ms_nxt  = ttl_ms_r;
    if (cfg_we) begin
      if (cfg_index == mfdf_pkg::REG_MY_NODE) begin
        my_node_nxt = cfg_wdata;
      end else begin
        ttl_ms_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_node_r <= '0;
      ttl_ms_r  <= mfdf_pkg::TTL_RESET;
    end else begin
      my_node_r <= my_node_nxt;
      ttl_ms_r  <= ttl_ms_nxt;
    end
  end

  assign busy   = q_full | clearing;
  assign push   = start & ~busy;
  assign ttl_ms = ttl_ms_r;
  assign dst_me = (in_dst_node == my_node_r);

  always_comb begin
    push_item.src_node  = in_src_node;
    push_item.packet_id = in_packet_id;
    push_item.now_ms    = in_now_ms;
    if (in_req_type) begin
      push_item.kind = mfdf_pkg::KIND_OWN;
    end else if (in_src_node == my_node_r) begin
      push_item.kind = mfdf_pkg::KIND_COLL;
    end else begin
      push_item.kind = mfdf_pkg::KIND_RX;
    end
    push_item.deliver    = dst_me | (in_dst_node == mfdf_pkg::BROADCAST_NODE);
    push_item.send_ack   = in_ack_wanted & dst_me;
    push_item.relay      = (in_hops_left != 3'd0);
    push_item.relay_hops = (in_hops_left != 3'd0) ? (in_hops_left - 3'd1) : 3'd0;
  end

endmodule

// ----- design/mfdf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdf_queue: command queue
// Short FIFO between the front end and the scan engine.
// ----------------------------------------------------------------------------
module mfdf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfdf_pkg::cmd_t push_item,
  input  logic           pop,
  output mfdf_pkg::cmd_t pop_item,
  output logic           full,
  output logic           empty
);

  mfdf_pkg::cmd_t                  slot_r [mfdf_pkg::QUEUE_DEPTH];
  logic [mfdf_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mfdf_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mfdf_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full     = (count_r == mfdf_pkg::QCNT_W'(mfdf_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mfdf_pkg::QPTR_W'(mfdf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mfdf_pkg::QPTR_W'(mfdf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- design/mfdf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfdf_back: cache scan engine
// Owns the duplicate cache memory. Clears it after reset, then for each
// lookup scans every entry, retires expired ones, stops on a live match
// and otherwise writes the key at the ring head. Drives the result strobe.
// ----------------------------------------------------------------------------
module mfdf_back #(
  parameter int CACHE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    ttl_ms,
  input  logic           q_empty,
  input  mfdf_pkg::cmd_t q_item,
  output logic           q_pop,
  output logic           clearing,
  output logic           out_strobe,
  output logic [1:0]     out_status,
  output logic           out_deliver,
  output logic           out_send_ack,
  output logic           out_relay,
  output logic [2:0]     out_relay_hops
);

  localparam int AW = $clog2(CACHE_DEPTH);
  localparam int CW = $clog2(CACHE_DEPTH + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  mfdf_pkg::entry_t mem [CACHE_DEPTH];
  mfdf_pkg::entry_t rd_q_r;

  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [AW-1:0]  pend_idx_r, pend_idx_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  mfdf_pkg::cmd_t cmd_r, cmd_nxt;

  logic           strobe_r, strobe_nxt;
  logic [1:0]     status_r, status_nxt;
  logic           deliver_r, deliver_nxt;
  logic           ack_r, ack_nxt;
  logic           relay_r, relay_nxt;
  logic [2:0]     hops_r, hops_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  mfdf_pkg::entry_t mem_wd;
  logic [AW-1:0]    rd_addr;

  logic [39:0] age;
  logic        ent_empty, ent_expired, ent_match;
  logic        is_own;

  assign rd_addr = (idx_r < CW'(CACHE_DEPTH)) ? idx_r[AW-1:0] : '0;

  assign age         = cmd_r.now_ms - rd_q_r.stamp;
  assign ent_empty   = (rd_q_r.source == '0) && (rd_q_r.ident == '0);
  assign ent_expired = (cmd_r.now_ms >= rd_q_r.stamp) && (age > {8'd0, ttl_ms});
  assign ent_match   = !ent_empty && !ent_expired &&
                       (rd_q_r.source == cmd_r.src_node) &&
                       (rd_q_r.ident == cmd_r.packet_id);
  assign is_own      = (cmd_r.kind == mfdf_pkg::KIND_OWN);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    pend_v_nxt   = 1'b0;
    pend_idx_nxt = pend_idx_r;
    head_nxt     = head_r;
    cmd_nxt      = cmd_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    deliver_nxt  = deliver_r;
    ack_nxt      = ack_r;
    relay_nxt    = relay_r;
    hops_nxt     = hops_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = '0;
    q_pop        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_r[AW-1:0];
        if (idx_r == CW'(CACHE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_item;
          if (q_item.kind == mfdf_pkg::KIND_COLL) begin
            strobe_nxt  = 1'b1;
            status_nxt  = mfdf_pkg::ST_COLLISION;
            deliver_nxt = 1'b0;
            ack_nxt     = 1'b0;
            relay_nxt   = 1'b0;
            hops_nxt    = 3'd0;
          end else begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        if (idx_r != CW'(CACHE_DEPTH)) begin
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = idx_r[AW-1:0];
          idx_nxt      = idx_r + 1'b1;
        end
        if (pend_v_r) begin
          if (!ent_empty && ent_expired) begin
            mem_we = 1'b1;
            mem_wa = pend_idx_r;
          end else if (ent_match) begin
            state_nxt   = S_IDLE;
            pend_v_nxt  = 1'b0;
            strobe_nxt  = 1'b1;
            status_nxt  = is_own ? mfdf_pkg::ST_REGISTERED : mfdf_pkg::ST_DUPLICATE;
            deliver_nxt = 1'b0;
            ack_nxt     = 1'b0;
            relay_nxt   = 1'b0;
            hops_nxt    = 3'd0;
          end
        end else if (idx_r == CW'(CACHE_DEPTH)) begin
          mem_we        = 1'b1;
          mem_wa        = head_r;
          mem_wd.source = cmd_r.src_node;
          mem_wd.ident  = cmd_r.packet_id;
          mem_wd.stamp  = cmd_r.now_ms;
          head_nxt      = (head_r == AW'(CACHE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          state_nxt     = S_IDLE;
          strobe_nxt    = 1'b1;
          status_nxt    = is_own ? mfdf_pkg::ST_REGISTERED : mfdf_pkg::ST_ACCEPTED;
          deliver_nxt   = !is_own && cmd_r.deliver;
          ack_nxt       = !is_own && cmd_r.send_ack;
          relay_nxt     = !is_own && cmd_r.relay;
          hops_nxt      = is_own ? 3'd0 : cmd_r.relay_hops;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      idx_r    <= '0;
      pend_v_r <= 1'b0;
      head_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      pend_v_r <= pend_v_nxt;
      head_r   <= head_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    deliver_r  <= deliver_nxt;
    ack_r      <= ack_nxt;
    relay_r    <= relay_nxt;
    hops_r     <= hops_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[rd_addr];
  end

  assign clearing       = (state_r == S_CLEAR);
  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_deliver    = deliver_r;
  assign out_send_ack   = ack_r;
  assign out_relay      = relay_r;
  assign out_relay_hops = hops_r;

endmodule

// ----- design/mesh_flood_dedup_filter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_flood_dedup_filter_unit: duplicate filter for a flooding mesh
// A header transfer happens on a clock edge with start high and busy low.
// Each header yields one result, shown for one cycle with out_strobe high:
// status, local delivery, ack request and relay with the decremented hop
// limit. The receiver cannot stall; results appear in transfer order.
// Configuration (cfg_index 0 node number, 1 ttl in ms) is written with
// cfg_we; the user must write it only while no header is in flight, as
// the block itself does not enforce it. An own-node collision returns in
// the cycle after it leaves the queue; any header passes through the queue
// registers and the engine's idle state before its result register. A lookup
// walks every cache entry through the single memory read port, and the engine
// finishes one header before it takes the next while the queue takes more.
// Two headers can wait in the command queue; busy rises when it is full.
// After reset the cache is cleared one entry per cycle, with busy held
// high; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module mesh_flood_dedup_filter_unit #(
  parameter int CACHE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [31:0]                    in_src_node,
  input  logic [31:0]                    in_dst_node,
  input  logic [31:0]                    in_packet_id,
  input  logic [2:0]                     in_hops_left,
  input  logic                           in_ack_wanted,
  input  logic [39:0]                    in_now_ms,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic                           out_deliver,
  output logic                           out_send_ack,
  output logic                           out_relay,
  output logic [2:0]                     out_relay_hops,
  input  logic                           cfg_we,
  input  logic [mfdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  logic           push, pop, q_full, q_empty, clearing;
  mfdf_pkg::cmd_t push_item, pop_item;
  logic [31:0]    ttl_ms;

  mfdf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_src_node   (in_src_node),
    .in_dst_node   (in_dst_node),
    .in_packet_id  (in_packet_id),
    .in_hops_left  (in_hops_left),
    .in_ack_wanted (in_ack_wanted),
    .in_now_ms     (in_now_ms),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_full        (q_full),
    .clearing      (clearing),
    .push          (push),
    .push_item     (push_item),
    .ttl_ms        (ttl_ms)
  );

  mfdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  mfdf_back #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ttl_ms         (ttl_ms),
    .q_empty        (q_empty),
    .q_item         (pop_item),
    .q_pop          (pop),
    .clearing       (clearing),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_deliver    (out_deliver),
    .out_send_ack   (out_send_ack),
    .out_relay      (out_relay),
    .out_relay_hops (out_relay_hops)
  );

endmodule

// ----- tb/mesh_flood_dedup_filter_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_flood_dedup_filter_unit_tb: self-checking bench for the flood filter
// Drives decoded headers through the start/busy port and keeps a shadow of
// the duplicate cache and registers. Each header transfer yields a predicted
// verdict, which is matched against the strobed result in order. Directed
// cases cover actions, duplicates, own sends, the zero key, expiry, time
// running backwards and field extremes. Random phases follow, each under
// its own register setting, mostly with bursty sender timing.
// ----------------------------------------------------------------------------
module mesh_flood_dedup_filter_unit_tb;

  localparam int          CACHE_DEPTH  = 256;
  localparam longint      RUN_LIMIT_NS = 64'd20_000_000;
  localparam logic        REQ_RX       = 1'b0;
  localparam logic        REQ_OWN      = 1'b1;
  localparam logic [31:0] NODE_A       = 32'hA5C3_0F96;

  typedef struct packed {
    logic        req;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ident;
    logic [2:0]  hops;
    logic        ackw;
    logic [39:0] now;
  } header_t;

  typedef struct packed {
    logic [1:0] status;
    logic       deliver;
    logic       send_ack;
    logic       relay;
    logic [2:0] relay_hops;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           in_req_type = 1'b0;
  logic [31:0]                    in_src_node = '0;
  logic [31:0]                    in_dst_node = '0;
  logic [31:0]                    in_packet_id = '0;
  logic [2:0]                     in_hops_left = '0;
  logic                           in_ack_wanted = 1'b0;
  logic [39:0]                    in_now_ms = '0;
  logic                           out_strobe;
  logic [1:0]                     out_status;
  logic                           out_deliver;
  logic                           out_send_ack;
  logic                           out_relay;
  logic [2:0]                     out_relay_hops;
  logic                           cfg_we = 1'b0;
  logic [mfdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                    cfg_wdata = '0;

  logic [31:0] local_node = '0;
  logic [31:0] ttl_val = mfdf_pkg::TTL_RESET;
  logic [31:0] shadow_src [CACHE_DEPTH] = '{default: '0};
  logic [31:0] shadow_id [CACHE_DEPTH] = '{default: '0};
  logic [39:0] shadow_stamp [CACHE_DEPTH] = '{default: '0};
  int          shadow_head = 0;

  verdict_t    pending_verdicts[$];
  logic [63:0] recent_keys[$];
  logic [39:0] clock_ms = '0;
  int          fail_count = 0;
  int          burst_left = 0;
  int          idle_limit = 3;

  mesh_flood_dedup_filter_unit #(
    .CACHE_DEPTH(CACHE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_src_node   (in_src_node),
    .in_dst_node   (in_dst_node),
    .in_packet_id  (in_packet_id),
    .in_hops_left  (in_hops_left),
    .in_ack_wanted (in_ack_wanted),
    .in_now_ms     (in_now_ms),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_deliver   (out_deliver),
    .out_send_ack  (out_send_ack),
    .out_relay     (out_relay),
    .out_relay_hops(out_relay_hops),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Live match returns 1; otherwise the key is written at the ring head.
  function automatic bit cache_seen(input logic [31:0] src, input logic [31:0] ident,
                                    input logic [39:0] now);
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (shadow_src[i] == '0 && shadow_id[i] == '0)
        continue;
      if (now >= shadow_stamp[i] && (now - shadow_stamp[i]) > {8'd0, ttl_val}) begin
        shadow_src[i] = '0;
        shadow_id[i] = '0;
        shadow_stamp[i] = '0;
        continue;
      end
      if (shadow_src[i] == src && shadow_id[i] == ident)
        return 1'b1;
    end
    shadow_src[shadow_head] = src;
    shadow_id[shadow_head] = ident;
    shadow_stamp[shadow_head] = now;
    shadow_head = (shadow_head + 1) % CACHE_DEPTH;
    return 1'b0;
  endfunction

  function automatic verdict_t filter_verdict(input header_t h);
    verdict_t v;
    v = '0;
    if (h.req == REQ_OWN) begin
      void'(cache_seen(h.src, h.ident, h.now));
      v.status = mfdf_pkg::ST_REGISTERED;
    end else if (h.src == local_node) begin
      v.status = mfdf_pkg::ST_COLLISION;
    end else if (cache_seen(h.src, h.ident, h.now)) begin
      v.status = mfdf_pkg::ST_DUPLICATE;
    end else begin
      v.status = mfdf_pkg::ST_ACCEPTED;
      v.deliver = (h.dst == local_node) || (h.dst == mfdf_pkg::BROADCAST_NODE);
      v.send_ack = h.ackw && (h.dst == local_node);
      v.relay = (h.hops != 3'd0);
      v.relay_hops = v.relay ? h.hops - 3'd1 : 3'd0;
    end
    return v;
  endfunction

  function automatic header_t header(input logic req, input logic [31:0] src,
                                     input logic [31:0] dst, input logic [31:0] ident,
                                     input logic [2:0] hops, input logic ackw,
                                     input logic [39:0] now);
    header_t h;
    h.req = req;
    h.src = src;
    h.dst = dst;
    h.ident = ident;
    h.hops = hops;
    h.ackw = ackw;
    h.now = now;
    return h;
  endfunction

  // Entered and left right after a rising edge.
  task automatic send_header(input header_t h);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (idle_limit > 0)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
                                           : $urandom_range(0, idle_limit);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= h.req;
    in_src_node <= h.src;
    in_dst_node <= h.dst;
    in_packet_id <= h.ident;
    in_hops_left <= h.hops;
    in_ack_wanted <= h.ackw;
    in_now_ms <= h.now;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_verdicts.push_back(filter_verdict(h));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] node, input logic [31:0] ttl);
    cfg_we <= 1'b1;
    cfg_index <= mfdf_pkg::REG_MY_NODE;
    cfg_wdata <= node;
    @(posedge clk);
    cfg_index <= mfdf_pkg::REG_TTL_MS;
    cfg_wdata <= ttl;
    @(posedge clk);
    cfg_we <= 1'b0;
    local_node = node;
    ttl_val = ttl;
  endtask

  task automatic report_mismatch(input string field, input longint unsigned want_v,
                                 input longint unsigned got_v);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
  endtask

  always @(negedge clk) begin
    verdict_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        $display("%0t: result with no transfer pending, expected none, actual status %0h",
                 $time, out_status);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", want.status, out_status);
        if (out_deliver !== want.deliver)
          report_mismatch("deliver", want.deliver, out_deliver);
        if (out_send_ack !== want.send_ack)
          report_mismatch("send_ack", want.send_ack, out_send_ack);
        if (out_relay !== want.relay)
          report_mismatch("relay", want.relay, out_relay);
        if (out_relay_hops !== want.relay_hops)
          report_mismatch("relay_hops", want.relay_hops, out_relay_hops);
      end
    end
  end

  // Register defaults: node 0, ttl of ten minutes.
  task automatic test_reset_values();
    send_header(header(REQ_RX, 32'h1234, 32'h0, 32'h1, 3'd2, 1'b1, 40'd1000));
    send_header(header(REQ_RX, 32'h1234, 32'h0, 32'h1, 3'd2, 1'b1, 40'd601000));
    send_header(header(REQ_RX, 32'h1234, 32'h0, 32'h1, 3'd2, 1'b1, 40'd601001));
    send_header(header(REQ_RX, 32'h0, 32'h0, 32'h9, 3'd1, 1'b0, 40'd601001));
  endtask

  task automatic test_actions();
    drain_results();
    configure(NODE_A, 32'd100);
    send_header(header(REQ_RX, 32'h11, NODE_A, 32'h100, 3'd7, 1'b1, 40'd5000));
    send_header(header(REQ_RX, 32'h11, mfdf_pkg::BROADCAST_NODE, 32'h101, 3'd0, 1'b1,
                       40'd5000));
    send_header(header(REQ_RX, 32'h12, 32'h5555, 32'h102, 3'd1, 1'b1, 40'd5010));
    send_header(header(REQ_RX, NODE_A, NODE_A, 32'h103, 3'd4, 1'b1, 40'd5020));
    send_header(header(REQ_RX, 32'h11, NODE_A, 32'h100, 3'd7, 1'b1, 40'd5050));
  endtask

  task automatic test_own_and_zero_key();
    send_header(header(REQ_OWN, 32'h22, NODE_A, 32'h200, 3'd3, 1'b1, 40'd5100));
    send_header(header(REQ_OWN, 32'h22, 32'h7, 32'h200, 3'd0, 1'b0, 40'd5101));
    send_header(header(REQ_RX, 32'h22, NODE_A, 32'h200, 3'd3, 1'b1, 40'd5102));
    send_header(header(REQ_RX, 32'h22, NODE_A, 32'h201, 3'd3, 1'b0, 40'd5103));
    send_header(header(REQ_RX, 32'h0, mfdf_pkg::BROADCAST_NODE, 32'h0, 3'd2, 1'b0,
                       40'd5104));
    send_header(header(REQ_RX, 32'h0, mfdf_pkg::BROADCAST_NODE, 32'h0, 3'd2, 1'b0,
                       40'd5105));
  endtask

  task automatic test_expiry_and_backwards();
    send_header(header(REQ_RX, 32'h33, 32'h44, 32'h300, 3'd5, 1'b0, 40'd10000));
    send_header(header(REQ_RX, 32'h33, 32'h44, 32'h300, 3'd5, 1'b0, 40'd10100));
    send_header(header(REQ_RX, 32'h33, 32'h44, 32'h300, 3'd5, 1'b0, 40'd10101));
    send_header(header(REQ_RX, 32'h33, 32'h44, 32'h300, 3'd5, 1'b0, 40'd9000));
  endtask

  task automatic test_extremes();
    drain_results();
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(header(REQ_RX, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1,
                       40'hFF_FFFF_FFFF));
    send_header(header(REQ_RX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1,
                       40'hFF_FFFF_FFFF));
    send_header(header(REQ_OWN, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 3'd7, 1'b1,
                       40'hFF_FFFF_FFFF));
  endtask

  task automatic test_zero_ttl();
    drain_results();
    configure(32'h0, 32'h0);
    send_header(header(REQ_RX, 32'h0, 32'h0, 32'h0, 3'd1, 1'b1, 40'd0));
    send_header(header(REQ_RX, 32'h5, 32'h0, 32'h5, 3'd1, 1'b1, 40'd0));
    send_header(header(REQ_RX, 32'h5, 32'h0, 32'h5, 3'd1, 1'b1, 40'd0));
    send_header(header(REQ_RX, 32'h5, 32'h0, 32'h5, 3'd1, 1'b1, 40'd1));
  endtask

  // Replays of recent keys, with fresh headers mixed in about as often.
  task automatic test_random_traffic(input int count, input logic [31:0] node,
                                     input logic [31:0] ttl, input int idle,
                                     input bit paced);
    header_t     h;
    logic [63:0] key;
    int          pick;
    int          idx;
    drain_results();
    configure(node, ttl);
    idle_limit = idle;
    burst_left = 0;
    clock_ms = {8'($urandom_range(0, 255)), $urandom};
    repeat (count) begin
      pick = $urandom_range(0, 99);
      idx = (recent_keys.size() != 0) ? $urandom_range(0, recent_keys.size() - 1) : 0;
      if (pick < 40 && recent_keys.size() != 0)
        key = recent_keys[idx];
      else if (pick < 48)
        key = {local_node, $urandom};
      else if (pick < 52)
        key = '0;
      else if (pick < 60 && recent_keys.size() != 0)
        key = {recent_keys[idx][63:32], $urandom};
      else
        key = {$urandom, $urandom};
      recent_keys.push_back(key);
      if (recent_keys.size() > 24)
        void'(recent_keys.pop_front());

      pick = $urandom_range(0, 99);
      if (pick < 3)
        clock_ms -= 40'($urandom_range(0, 50));
      else if (pick < 5)
        clock_ms = {8'($urandom), $urandom};
      else if (pick < 15)
        clock_ms += 40'(ttl_val) + 40'($urandom_range(0, 1));
      else if (pick >= 40)
        clock_ms += 40'($urandom % (ttl_val / 8 + 1));

      h.req = ($urandom_range(0, 3) == 0) ? REQ_OWN : REQ_RX;
      h.src = key[63:32];
      h.ident = key[31:0];
      pick = $urandom_range(0, 9);
      h.dst = (pick < 3) ? local_node : (pick < 5) ? mfdf_pkg::BROADCAST_NODE : $urandom;
      h.hops = 3'($urandom_range(0, 7));
      h.ackw = 1'($urandom_range(0, 1));
      h.now = clock_ms;
      if (paced)
        drain_results();
      send_header(h);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_actions();
    test_own_and_zero_key();
    test_expiry_and_backwards();
    test_extremes();
    test_zero_ttl();
    test_random_traffic(400, $urandom, mfdf_pkg::TTL_RESET, 8, 1'b0);
    test_random_traffic(200, 32'h0, 32'h0, 0, 1'b0);
    test_random_traffic(250, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20, 1'b0);
    test_random_traffic(350, $urandom, $urandom_range(1, 500), 4, 1'b0);
    // one header at a time, each after the previous result is back
    test_random_traffic(12, $urandom, 32'd3000, 2, 1'b1);
    test_random_traffic(240, $urandom, $urandom, 6, 1'b0);
    drain_results();
    repeat (CACHE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
